// File: sv/kmi_pkg.sv
// ----------------------------------------------------------------------------
// kmi_pkg: shared types and constants for the neighbor mean imputation block
// Request, status and config index codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package kmi_pkg;

	localparam int unsigned SampleRowsDef = 1024;
	localparam int unsigned RefRowsDef    = 1024;
	localparam int unsigned NumColsDef    = 16;
	localparam int unsigned MaxSlotsDef   = 16;

	localparam int unsigned ValW   = 32;
	localparam int unsigned RowW   = 10;
	localparam int unsigned ColW   = 4;
	localparam int unsigned SlotW  = 4;
	localparam int unsigned CntW   = 5;
	localparam int unsigned RefUsW = 11;

	typedef enum logic [2:0] {
		REQ_WR_INDEX = 3'd0,
		REQ_WR_REF   = 3'd1,
		REQ_WR_FB    = 3'd2,
		REQ_SET_CNT  = 3'd3,
		REQ_QUERY    = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		ST_PASS    = 3'd0,
		ST_NB_MEAN = 3'd1,
		ST_FB_MEAN = 3'd2,
		ST_BAD_IDX = 3'd3,
		ST_FB_MISS = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CFG_DEF_NB    = 2'd0,
		CFG_CNT_MISS  = 2'd1,
		CFG_REF_USED  = 2'd2,
		CFG_SLOT_USED = 2'd3
	} cfg_idx_t;

endpackage

// File: sv/kmi_div.sv
// ----------------------------------------------------------------------------
// kmi_div: signed 37-bit by 5-bit divider, one quotient bit per cycle
// Truncates toward zero; quotient is known to fit 32 bits.
// ----------------------------------------------------------------------------
module kmi_div
	import kmi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic signed [36:0] dividend,
	input  logic [CntW-1:0]   divisor,
	output logic              done,
	output logic [ValW-1:0]   quotient
);

	logic [36:0] mag_q;
	logic [36:0] quo_q;
	logic [CntW:0] rem_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic        busy_q;
	logic [CntW-1:0] dvs_q;
	logic [CntW:0] trial;
	logic [36:0] neg_quo;

	assign trial   = {rem_q[CntW-1:0], mag_q[36]};
	assign neg_quo = -quo_q;

	// restoring divide on magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd37;
				neg_q  <= dividend[36];
				mag_q  <= dividend[36] ? -dividend : dividend;
				quo_q  <= '0;
				rem_q  <= '0;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				mag_q <= {mag_q[35:0], 1'b0};
				if (trial >= {1'b0, dvs_q}) begin
					rem_q <= trial - {1'b0, dvs_q};
					quo_q <= {quo_q[35:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[35:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign quotient = neg_q ? neg_quo[ValW-1:0] : quo_q[ValW-1:0];

endmodule

// File: sv/knn_mean_imputation.sv
// Neighbor mean imputation. Writes complete on acceptance. A present query value
// goes via S_OUT to the output register; input is ready again as it is issued.
// A missing value walks neighbor slots one per cycle through the index and
// table memories (two-stage read), up to two passes of at most 16 slots, then a
// serial divide in the shared divider to the result word; errors give theirs sooner.
// A result still waiting in the output register holds the next one back.
// Reset (arst_n low) clears control and config registers; memories undefined.
// ----------------------------------------------------------------------------
// knn_mean_imputation: top level
// Four memories, a slot-walk sequencer and a shared serial divider.
// ----------------------------------------------------------------------------
module knn_mean_imputation
	import kmi_pkg::*;
#(
	parameter int unsigned SAMPLE_ROWS = SampleRowsDef,
	parameter int unsigned REF_ROWS    = RefRowsDef,
	parameter int unsigned NUM_COLS    = NumColsDef,
	parameter int unsigned MAX_SLOTS   = MaxSlotsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// req_type[2:0], row[12:3], col[16:13], slot[20:17], neighbor_row[30:21],
	// value[62:31], value_missing[63], col_neighbors[68:64]
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// result_value[31:0], status[34:32]
	output logic [39:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	localparam int unsigned ClAw  = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
	localparam int unsigned IdxD  = SAMPLE_ROWS * MAX_SLOTS;
	localparam int unsigned TabD  = REF_ROWS * NUM_COLS;
	localparam int unsigned IdxAw = (IdxD > 1) ? $clog2(IdxD) : 1;
	localparam int unsigned TabAw = (TabD > 1) ? $clog2(TabD) : 1;
	localparam logic [SlotW:0] MaxSl = (SlotW+1)'(MAX_SLOTS > 16 ? 16 : MAX_SLOTS);
	localparam logic [RefUsW-1:0] RefLim =
		RefUsW'(REF_ROWS > 1024 ? 1024 : REF_ROWS);

	// input fields
	logic [2:0]      f_req;
	logic [RowW-1:0] f_row;
	logic [ColW-1:0] f_col;
	logic [SlotW-1:0] f_slot;
	logic [RowW-1:0] f_nrow;
	logic [ValW-1:0] f_val;
	logic            f_miss;
	logic [CntW-1:0] f_cn;
	assign f_req  = s_tdata[2:0];
	assign f_row  = s_tdata[12:3];
	assign f_col  = s_tdata[16:13];
	assign f_slot = s_tdata[20:17];
	assign f_nrow = s_tdata[30:21];
	assign f_val  = s_tdata[62:31];
	assign f_miss = s_tdata[63];
	assign f_cn   = s_tdata[68:64];

	// config registers
	logic [CntW-1:0]   def_nb_q;
	logic              cnt_miss_q;
	logic [RefUsW-1:0] ref_used_q;
	logic [CntW-1:0]   slot_used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_nb_q    <= CntW'(1);
			cnt_miss_q  <= 1'b0;
			ref_used_q  <= RefUsW'(1024);
			slot_used_q <= CntW'(16);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DEF_NB:    def_nb_q    <= cfg_data[CntW-1:0];
				CFG_CNT_MISS:  cnt_miss_q  <= cfg_data[0];
				CFG_REF_USED:  ref_used_q  <= cfg_data;
				CFG_SLOT_USED: slot_used_q <= cfg_data[CntW-1:0];
				default: ;
			endcase
		end
	end

	// memories
	logic [RowW-1:0] idx_mem [IdxD];
	logic [ValW:0]   ref_mem [TabD];
	logic [ValW:0]   fb_mem  [TabD];
	logic [CntW-1:0] cnt_mem [NUM_COLS];

	typedef enum logic [2:0] {
		S_IDLE, S_CNT, S_WALK, S_DIV, S_OUT
	} state_t;
	state_t state_q;

	logic          acc;
	logic          pass_fb_q;    // 0 neighbor pass, 1 fallback pass
	logic [RowW-1:0] row_q;
	logic [ColW-1:0] col_q;
	logic [SlotW:0]  iss_q;      // next slot to issue
	logic          v1_s1, v2_s2; // pipeline valid: index read, table read
	logic [SlotW:0]  want_q, nb_q, cnt_q, lim_q;
	logic signed [36:0] sum_q;
	logic [ValW-1:0] res_q;
	logic [2:0]      st_q;
	logic [RowW-1:0] nidx;
	logic [ValW:0]   tab_s2;
	logic            row_ok, col_ok, nidx_ok, r_ok_s2;
	logic [SlotW:0]  slots;
	logic [SlotW:0]  kfb;
	logic            div_start, div_done;
	logic [ValW-1:0] div_q;
	logic [SlotW:0]  nb_next;

	assign acc    = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign row_ok = 32'(f_row) < SAMPLE_ROWS;
	assign col_ok = 32'(f_col) < NUM_COLS;
	assign slots  = (slot_used_q > MaxSl) ? MaxSl : slot_used_q;
	assign kfb    = (def_nb_q < slots) ? def_nb_q : slots;

	// writes and count read
	logic [IdxAw-1:0] idx_waddr, idx_raddr;
	logic [TabAw-1:0] tab_waddr, tab_raddr;
	assign idx_waddr = IdxAw'(32'(f_row) * MAX_SLOTS + 32'(f_slot));
	assign tab_waddr = TabAw'(32'(f_row) * NUM_COLS + 32'(f_col));
	assign idx_raddr = IdxAw'(32'(row_q) * MAX_SLOTS + 32'(iss_q[SlotW-1:0]));
	assign tab_raddr = TabAw'(32'(nidx) * NUM_COLS + 32'(col_q));

	logic [CntW-1:0] cnt_rd;
	always_ff @(posedge clk) begin
		if (acc && f_req == REQ_WR_INDEX && row_ok && 32'(f_slot) < MAX_SLOTS)
			idx_mem[idx_waddr] <= f_nrow;
		if (acc && f_req == REQ_WR_REF && 32'(f_row) < REF_ROWS && col_ok)
			ref_mem[tab_waddr] <= {f_miss, f_val};
		if (acc && f_req == REQ_WR_FB && 32'(f_row) < REF_ROWS && col_ok)
			fb_mem[tab_waddr] <= {f_miss, f_val};
		if (acc && f_req == REQ_SET_CNT && col_ok)
			cnt_mem[ClAw'(f_col)] <= f_cn;
		cnt_rd <= cnt_mem[ClAw'(f_col)];
		nidx   <= idx_mem[idx_raddr];
		tab_s2 <= pass_fb_q ? fb_mem[tab_raddr] : ref_mem[tab_raddr];
		r_ok_s2 <= nidx_ok;
	end
	assign nidx_ok = {1'b0, nidx} < ref_used_q && {1'b0, nidx} < RefLim;

	// per-pass issue limit
	logic issue;
	logic stop_nb;
	assign stop_nb = !pass_fb_q && (nb_next >= want_q);
	assign issue   = (state_q == S_WALK) && (iss_q < lim_q);
	assign nb_next = nb_q + (((!tab_s2[ValW]) || cnt_miss_q) ? 1'b1 : 1'b0);

	// end of a neighbor pass on reaching the count; pass fully drained
	logic flush, drained, start_div;
	assign flush     = v2_s2 && r_ok_s2 && !pass_fb_q && stop_nb;
	assign drained   = !v2_s2 && !v1_s1 && !issue;
	assign start_div = (state_q == S_WALK) && drained && (pass_fb_q || cnt_q != '0);

	kmi_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(sum_q), .divisor(cnt_q[CntW-1:0]),
		.done(div_done), .quotient(div_q)
	);

	// sequencer: slots issue one per cycle; a terminating slot flushes the rest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_tvalid  <= 1'b0;
			v1_s1     <= 1'b0;
			v2_s2     <= 1'b0;
			div_start <= 1'b0;
		end else begin
			div_start <= start_div;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc && f_req == REQ_QUERY) begin
						row_q <= f_row;
						col_q <= f_col;
						if (!f_miss) begin
							res_q   <= f_val;
							st_q    <= ST_PASS;
							state_q <= S_OUT;
						end else if (!row_ok || !col_ok) begin
							res_q   <= '0;
							st_q    <= ST_BAD_IDX;
							state_q <= S_OUT;
						end else begin
							state_q <= S_CNT;
						end
					end
				end
				S_CNT: begin
					want_q    <= cnt_rd;
					lim_q     <= (cnt_rd == '0) ? '0 : slots;
					pass_fb_q <= 1'b0;
					iss_q     <= '0;
					nb_q      <= '0;
					cnt_q     <= '0;
					sum_q     <= '0;
					v1_s1     <= 1'b0;
					v2_s2     <= 1'b0;
					state_q   <= S_WALK;
				end
				S_WALK: begin
					v1_s1 <= issue && !flush;
					v2_s2 <= v1_s1 && !flush;
					if (v2_s2 && !r_ok_s2) begin
						res_q <= '0; st_q <= ST_BAD_IDX; state_q <= S_OUT;
					end else if (v2_s2 && pass_fb_q && tab_s2[ValW]) begin
						res_q <= '0; st_q <= ST_FB_MISS; state_q <= S_OUT;
					end else if (flush) begin
						if (!tab_s2[ValW]) begin
							sum_q <= sum_q + 37'(signed'(tab_s2[ValW-1:0]));
							cnt_q <= cnt_q + 1'b1;
						end
						nb_q  <= nb_next;
						lim_q <= '0;
						iss_q <= '0;
					end else begin
						if (issue) iss_q <= iss_q + 1'b1;
						if (v2_s2) begin
							if (pass_fb_q || !tab_s2[ValW]) begin
								sum_q <= sum_q + 37'(signed'(tab_s2[ValW-1:0]));
								cnt_q <= cnt_q + 1'b1;
							end
							nb_q <= nb_next;
						end else if (drained) begin
							// pass drained
							if (pass_fb_q || cnt_q != '0) begin
								st_q    <= pass_fb_q ? ST_FB_MEAN : ST_NB_MEAN;
								state_q <= S_DIV;
							end else if (kfb == '0) begin
								res_q <= '0; st_q <= ST_FB_MISS; state_q <= S_OUT;
							end else begin
								pass_fb_q <= 1'b1;
								lim_q     <= kfb;
								iss_q     <= '0;
								sum_q     <= '0;
								cnt_q     <= '0;
							end
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						res_q   <= div_q;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!m_tvalid) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {5'b0, st_q, res_q};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
